// File: rtl/i2cms_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
package i2cms_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam int UNIT_W        = 16;
   localparam int TIMEOUT_W     = 8;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = UNIT_W;

   localparam logic [UNIT_W-1:0]    UNIT_TICKS_RESET  = 16'd216;
   localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RESET = 8'd250;

   // register indexes on the csr port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_UNIT_TICKS  = 1'b0,
      CSR_ACK_TIMEOUT = 1'b1
   } csr_index_type;

   // command codes, equal to the kind field for the valid commands
   typedef enum logic [2:0] {
      CMD_TICK  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_WACK  = 3'd4,
      CMD_READ  = 3'd5
   } cmd_type;

   // one classified tick as it travels through the queue
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] tx_byte;
      logic       ack_after_read;
      logic       sda_sample;
   } item_type;

   // configuration seen by the sequencer
   typedef struct packed {
      logic [UNIT_W-1:0]    unit_ticks;
      logic [TIMEOUT_W-1:0] ack_timeout;
   } cfg_type;

endpackage

// File: rtl/i2cms_if.sv
// Channel interfaces: tick requests in, pin/status responses out.
interface i2cms_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] tx_byte;
   logic       ack_after_read;
   logic       sda_sample;

   modport source (output valid, kind, tx_byte, ack_after_read, sda_sample, input ready);
   modport sink   (input valid, kind, tx_byte, ack_after_read, sda_sample, output ready);
endinterface

interface i2cms_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       sda_is_input;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_data;
   logic       ack_failed;
   logic       rejected;

   modport source (output valid, scl_level, sda_level, sda_is_input, busy_res, done_res,
                   read_data, ack_failed, rejected, input ready);
   modport sink   (input valid, scl_level, sda_level, sda_is_input, busy_res, done_res,
                   read_data, ack_failed, rejected, output ready);
endinterface

// File: rtl/i2cms_front.sv
// Front stage: takes request beats and classifies the kind into a command.
module i2cms_front (
   input  logic                clock,
   input  logic                reset,
   i2cms_req_if.sink           req,
   output logic                item_valid,
   output i2cms_pkg::item_type item,
   input  logic                item_ready
);

   logic                fr_valid_ff, fr_valid_in;
   i2cms_pkg::item_type fr_item_ff, fr_item_in;
   logic                accept;

   assign req.ready = !fr_valid_ff || item_ready;
   assign accept    = req.valid && req.ready;

   // classify: unused kinds behave as a plain tick
   always_comb begin
      fr_item_in.tx_byte        = req.tx_byte;
      fr_item_in.ack_after_read = req.ack_after_read;
      fr_item_in.sda_sample     = req.sda_sample;
      case (req.kind)
         i2cms_pkg::CMD_START: fr_item_in.cmd = i2cms_pkg::CMD_START;
         i2cms_pkg::CMD_STOP:  fr_item_in.cmd = i2cms_pkg::CMD_STOP;
         i2cms_pkg::CMD_WRITE: fr_item_in.cmd = i2cms_pkg::CMD_WRITE;
         i2cms_pkg::CMD_WACK:  fr_item_in.cmd = i2cms_pkg::CMD_WACK;
         i2cms_pkg::CMD_READ:  fr_item_in.cmd = i2cms_pkg::CMD_READ;
         default:              fr_item_in.cmd = i2cms_pkg::CMD_TICK;
      endcase
   end

   assign fr_valid_in = accept || (fr_valid_ff && !item_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
      if (accept) begin
         fr_item_ff <= fr_item_in;
      end
   end

   assign item_valid = fr_valid_ff;
   assign item       = fr_item_ff;

endmodule

// File: rtl/i2cms_queue.sv
// Short FIFO between the classifier and the sequencer.
module i2cms_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  i2cms_pkg::item_type push_item,
   output logic                push_ready,
   output logic                pop_valid,
   output i2cms_pkg::item_type pop_item,
   input  logic                pop_ready
);

   i2cms_pkg::item_type                  slot_ff [i2cms_pkg::QUEUE_DEPTH];
   logic [i2cms_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [i2cms_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [i2cms_pkg::QCNT_W-1:0]         count_ff, count_in;
   logic                                 push, pop;

   assign push_ready = count_ff != i2cms_pkg::QCNT_W'(i2cms_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == i2cms_pkg::QPTR_W'(i2cms_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == i2cms_pkg::QPTR_W'(i2cms_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/i2cms_back.sv
// Back end: bus sequencer that advances one tick per beat, plus output register.
module i2cms_back (
   input  logic                clock,
   input  logic                reset,
   input  i2cms_pkg::cfg_type  cfg,
   input  logic                item_valid,
   input  i2cms_pkg::item_type item,
   output logic                item_ready,
   i2cms_rsp_if.source         rsp
);

   typedef enum logic [4:0] {
      PH_IDLE, PH_S1, PH_S2, PH_S3, PH_T1, PH_T2,
      PH_W0, PH_WB, PH_WH, PH_WL, PH_WN,
      PH_A1, PH_A2, PH_A3,
      PH_R0, PH_RB, PH_RH, PH_RN,
      PH_K1, PH_K2, PH_K3
   } phase_type;

   localparam int RUN_STEPS = 2;   // longest chain of phases done in one tick

   localparam logic [2:0] UNITS_4 = 3'd4;
   localparam logic [2:0] UNITS_2 = 3'd2;
   localparam logic [2:0] UNITS_1 = 3'd1;
   localparam logic [3:0] BYTE_BITS = 4'(i2cms_pkg::BITS_PER_BYTE);

   phase_type                     phase_ff, phase_in;
   i2cms_pkg::cmd_type            act_ff, act_in;
   logic [3:0]                    bits_ff, bits_in;
   logic [7:0]                    shift_ff, shift_in;
   logic [i2cms_pkg::UNIT_W-1:0]  delay_ff, delay_in;
   logic [2:0]                    units_ff, units_in;
   logic [i2cms_pkg::TIMEOUT_W-1:0] poll_ff, poll_in;
   logic                          scl_ff, scl_in;
   logic                          sda_ff, sda_in;
   logic                          dir_ff, dir_in;
   logic                          ackc_ff, ackc_in;
   logic                          fail_ff, fail_in;
   logic [7:0]                    last_ff, last_in;

   logic                          done_v, rej_v, run_v, go;
   logic [i2cms_pkg::UNIT_W-1:0]  unit_len, delay_dec;
   logic                          is_cmd, pop;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       o_scl_ff, o_sda_ff, o_dir_ff, o_busy_ff, o_done_ff, o_fail_ff, o_rej_ff;
   logic [7:0] o_data_ff;

   assign pop        = item_valid && (!rsp_valid_ff || rsp.ready);
   assign item_ready = !rsp_valid_ff || rsp.ready;
   assign is_cmd     = item.cmd != i2cms_pkg::CMD_TICK;
   assign unit_len   = (cfg.unit_ticks == '0) ? i2cms_pkg::UNIT_W'(1) : cfg.unit_ticks;
   assign delay_dec  = (delay_ff != '0) ? delay_ff - 1'b1 : '0;

   // next state for one tick
   always_comb begin
      phase_in = phase_ff;
      act_in   = act_ff;
      bits_in  = bits_ff;
      shift_in = shift_ff;
      delay_in = delay_ff;
      units_in = units_ff;
      poll_in  = poll_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      dir_in   = dir_ff;
      ackc_in  = ackc_ff;
      last_in  = last_ff;
      fail_in  = (phase_ff == PH_IDLE) ? 1'b0 : fail_ff;
      done_v   = 1'b0;
      rej_v    = 1'b0;
      run_v    = 1'b0;

      // launch a command, or count down the running wait
      if (phase_ff == PH_IDLE) begin
         if (is_cmd) begin
            act_in   = item.cmd;
            fail_in  = 1'b0;
            units_in = '0;
            run_v    = 1'b1;
            case (item.cmd)
               i2cms_pkg::CMD_START: phase_in = PH_S1;
               i2cms_pkg::CMD_STOP:  phase_in = PH_T1;
               i2cms_pkg::CMD_WRITE: begin
                  shift_in = item.tx_byte;
                  phase_in = PH_W0;
               end
               i2cms_pkg::CMD_WACK:  phase_in = PH_A1;
               i2cms_pkg::CMD_READ:  begin
                  ackc_in  = item.ack_after_read;
                  phase_in = PH_R0;
               end
               default: run_v = 1'b0;
            endcase
         end
      end else begin
         rej_v = is_cmd;
         if (units_ff != '0) begin
            if (delay_dec == '0) begin
               units_in = units_ff - 1'b1;
               if (units_in == '0) begin
                  run_v = 1'b1;
               end else begin
                  delay_in = unit_len;
               end
            end else begin
               delay_in = delay_dec;
            end
         end else begin
            run_v = 1'b1;
         end
      end

      // phase actions; pass-through phases chain into the next one
      go = run_v;
      for (int i = 0; i < RUN_STEPS; i++) begin
         if (go) begin
            go = 1'b0;
            case (phase_in)
               PH_S1: begin
                  dir_in = 1'b0; sda_in = 1'b1; scl_in = 1'b1;
                  units_in = UNITS_4; delay_in = unit_len; phase_in = PH_S2;
               end
               PH_S2: begin
                  sda_in = 1'b0;
                  units_in = UNITS_4; delay_in = unit_len; phase_in = PH_S3;
               end
               PH_S3: begin
                  scl_in = 1'b0; phase_in = PH_IDLE; done_v = 1'b1;
               end
               PH_T1: begin
                  dir_in = 1'b0; scl_in = 1'b0; sda_in = 1'b0;
                  units_in = UNITS_4; delay_in = unit_len; phase_in = PH_T2;
               end
               PH_T2: begin
                  scl_in = 1'b1; sda_in = 1'b1; phase_in = PH_IDLE; done_v = 1'b1;
               end
               PH_W0: begin
                  dir_in = 1'b0; scl_in = 1'b0; bits_in = '0;
                  phase_in = PH_WB; go = 1'b1;
               end
               PH_WB: begin
                  sda_in   = shift_in[7];
                  shift_in = {shift_in[6:0], 1'b0};
                  units_in = UNITS_2; delay_in = unit_len; phase_in = PH_WH;
               end
               PH_WH: begin
                  scl_in = 1'b1;
                  units_in = UNITS_2; delay_in = unit_len; phase_in = PH_WL;
               end
               PH_WL: begin
                  scl_in = 1'b0; bits_in = bits_in + 1'b1;
                  units_in = UNITS_2; delay_in = unit_len; phase_in = PH_WN;
               end
               PH_WN: begin
                  if (bits_in >= BYTE_BITS) begin
                     phase_in = PH_IDLE; done_v = 1'b1;
                  end else begin
                     phase_in = PH_WB; go = 1'b1;
                  end
               end
               PH_A1: begin
                  dir_in = 1'b1; sda_in = 1'b1; poll_in = '0;
                  units_in = UNITS_1; delay_in = unit_len; phase_in = PH_A2;
               end
               PH_A2: begin
                  scl_in = 1'b1;
                  units_in = UNITS_1; delay_in = unit_len; phase_in = PH_A3;
               end
               PH_A3: begin
                  if (!item.sda_sample) begin
                     scl_in = 1'b0; phase_in = PH_IDLE; done_v = 1'b1;
                  end else if (poll_in >= cfg.ack_timeout) begin
                     // timed out: fall into the stop sequence
                     fail_in = 1'b1; phase_in = PH_T1; go = 1'b1;
                  end else begin
                     poll_in = poll_in + 1'b1;
                  end
               end
               PH_R0: begin
                  dir_in = 1'b1; bits_in = '0; shift_in = '0;
                  phase_in = PH_RB; go = 1'b1;
               end
               PH_RB: begin
                  scl_in = 1'b0;
                  units_in = UNITS_2; delay_in = unit_len; phase_in = PH_RH;
               end
               PH_RH: begin
                  scl_in   = 1'b1;
                  shift_in = {shift_in[6:0], item.sda_sample};
                  bits_in  = bits_in + 1'b1;
                  units_in = UNITS_1; delay_in = unit_len; phase_in = PH_RN;
               end
               PH_RN: begin
                  phase_in = (bits_in >= BYTE_BITS) ? PH_K1 : PH_RB;
                  go = 1'b1;
               end
               PH_K1: begin
                  scl_in = 1'b0; dir_in = 1'b0; sda_in = !ackc_in;
                  units_in = UNITS_2; delay_in = unit_len; phase_in = PH_K2;
               end
               PH_K2: begin
                  scl_in = 1'b1;
                  units_in = UNITS_2; delay_in = unit_len; phase_in = PH_K3;
               end
               PH_K3: begin
                  scl_in = 1'b0; last_in = shift_in;
                  phase_in = PH_IDLE; done_v = 1'b1;
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp.ready);

   // sequencer state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         act_ff       <= i2cms_pkg::CMD_TICK;
         bits_ff      <= '0;
         shift_ff     <= '0;
         delay_ff     <= '0;
         units_ff     <= '0;
         poll_ff      <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         dir_ff       <= 1'b0;
         ackc_ff      <= 1'b0;
         fail_ff      <= 1'b0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff <= phase_in;
            act_ff   <= act_in;
            bits_ff  <= bits_in;
            shift_ff <= shift_in;
            delay_ff <= delay_in;
            units_ff <= units_in;
            poll_ff  <= poll_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
            dir_ff   <= dir_in;
            ackc_ff  <= ackc_in;
            fail_ff  <= fail_in;
            last_ff  <= last_in;
         end
      end
      if (pop) begin
         o_scl_ff  <= scl_in;
         o_sda_ff  <= dir_in ? 1'b1 : sda_in;
         o_dir_ff  <= dir_in;
         o_busy_ff <= phase_in != PH_IDLE;
         o_done_ff <= done_v;
         o_data_ff <= last_in;
         o_fail_ff <= done_v && (act_in == i2cms_pkg::CMD_WACK) && fail_in;
         o_rej_ff  <= rej_v;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.scl_level    = o_scl_ff;
   assign rsp.sda_level    = o_sda_ff;
   assign rsp.sda_is_input = o_dir_ff;
   assign rsp.busy_res     = o_busy_ff;
   assign rsp.done_res     = o_done_ff;
   assign rsp.read_data    = o_data_ff;
   assign rsp.ack_failed   = o_fail_ff;
   assign rsp.rejected     = o_rej_ff;

endmodule

// File: rtl/i2c_master_bit_sequencer_top.sv
// Top level of the I2C master bit sequencer: front, queue, sequencer, csr registers.
//
//   channel   | dir | beat
//   ----------+-----+------------------------------------------------------
//   req_chan  | in  | one clock tick: kind, tx_byte, ack_after_read, sda_sample
//   rsp_chan  | out | pin levels and status after that tick
//   csr_*     | in  | write of unit_ticks (index 0) or ack_timeout (index 1)
//
// One request beat per cycle, one response beat per request.
// A beat passes the classify register, the queue and the sequencer output register, in that order.
// The sequencer computes a whole tick, including chained phases, combinationally.
// Synchronous active-high reset; csr registers return to 216 and 250.
// Either side may stall; the two-entry queue and output register absorb it.
module i2c_master_bit_sequencer_top (
   input  logic                                 clock,
   input  logic                                 reset,
   i2cms_req_if.sink                            req_chan,
   i2cms_rsp_if.source                          rsp_chan,
   input  logic                                 csr_we,
   input  logic [i2cms_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [i2cms_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [i2cms_pkg::UNIT_W-1:0]    unit_ticks_ff, unit_ticks_in;
   logic [i2cms_pkg::TIMEOUT_W-1:0] ack_timeout_ff, ack_timeout_in;
   i2cms_pkg::cfg_type              cfg;

   logic                fr_valid, fr_ready;
   i2cms_pkg::item_type fr_item;
   logic                q_valid, q_ready;
   i2cms_pkg::item_type q_item;

   // configuration registers
   always_comb begin
      unit_ticks_in  = unit_ticks_ff;
      ack_timeout_in = ack_timeout_ff;
      if (csr_we) begin
         case (i2cms_pkg::csr_index_type'(csr_index))
            i2cms_pkg::CSR_UNIT_TICKS:  unit_ticks_in  = csr_wdata[i2cms_pkg::UNIT_W-1:0];
            i2cms_pkg::CSR_ACK_TIMEOUT: ack_timeout_in = csr_wdata[i2cms_pkg::TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff  <= i2cms_pkg::UNIT_TICKS_RESET;
         ack_timeout_ff <= i2cms_pkg::ACK_TIMEOUT_RESET;
      end else begin
         unit_ticks_ff  <= unit_ticks_in;
         ack_timeout_ff <= ack_timeout_in;
      end
   end

   assign cfg.unit_ticks  = unit_ticks_ff;
   assign cfg.ack_timeout = ack_timeout_ff;

   i2cms_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .item_valid (fr_valid),
      .item       (fr_item),
      .item_ready (fr_ready)
   );

   i2cms_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_item  (fr_item),
      .push_ready (fr_ready),
      .pop_valid  (q_valid),
      .pop_item   (q_item),
      .pop_ready  (q_ready)
   );

   i2cms_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (q_valid),
      .item       (q_item),
      .item_ready (q_ready),
      .rsp        (rsp_chan)
   );

   // a completed sequence leaves the block idle
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.done_res |-> !rsp_chan.busy_res)
      else $error("done beat reports busy");

   // a timeout is only reported on the done beat
   a_fail_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ack_failed |-> rsp_chan.done_res)
      else $error("ack failure outside done beat");

   // released SDA reads back as high
   a_released_high: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.sda_is_input |-> rsp_chan.sda_level)
      else $error("sda driven low while released");

   // a rejected command can only come while a sequence runs
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.rejected |-> rsp_chan.busy_res || rsp_chan.done_res)
      else $error("command rejected while idle");

endmodule

// File: tb/tb_i2c_master_bit_sequencer_top.sv
`timescale 1ns / 100ps
// Self-checking testbench: drives tick beats, predicts pins and status per tick, compares.
module tb_i2c_master_bit_sequencer_top;

   localparam int          CYCLE_LIMIT     = 3_000_000;
   localparam int          SETTLE_CYCLES   = 8;
   localparam int          RAND_PHASES     = 5;
   localparam int          ITEMS_PER_PHASE = 90;
   localparam int          MAX_PRINTED     = 30;
   localparam logic [2:0]  KIND_SPARE_6    = 3'd6;
   localparam logic [2:0]  KIND_SPARE_7    = 3'd7;
   localparam int          SDA_LOW         = 0;
   localparam int          SDA_HIGH        = 1;
   localparam int          SDA_RANDOM      = 2;

   // one request beat
   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] tx;
      logic       ack;
      logic       sda;
   } tick_item_type;

   // one response beat
   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       sda_in;
      logic       busy;
      logic       done;
      logic [7:0] rdata;
      logic       failed;
      logic       rejected;
   } tick_result_type;

   // directed stimulus row
   typedef struct packed {
      tick_item_type   stim;
      logic            hold;    // keep ticking at this SDA level until the sequence ends
      logic            typed;   // compare against want instead of the predicted beat
      logic            quick;   // drain, then switch to one-tick units before this row
      tick_result_type want;
   } plan_row_type;

   // sequencer phases of the predictor
   typedef enum logic [4:0] {
      SP_IDLE, SP_START_A, SP_START_B, SP_START_C, SP_STOP_A, SP_STOP_B,
      SP_WR_INIT, SP_WR_BIT, SP_WR_HIGH, SP_WR_LOW, SP_WR_NEXT,
      SP_ACK_REL, SP_ACK_HIGH, SP_ACK_POLL,
      SP_RD_INIT, SP_RD_LOW, SP_RD_HIGH, SP_RD_NEXT, SP_RD_ACK, SP_RD_ACKH, SP_RD_ACKL
   } seq_phase_type;

   localparam tick_result_type AFTER_RESET = '{scl: 1'b1, sda: 1'b1, sda_in: 1'b0,
                                               busy: 1'b0, done: 1'b0, rdata: 8'h00,
                                               failed: 1'b0, rejected: 1'b0};
   localparam tick_result_type NO_RESULT = '0;

   // quick rows run at one tick per unit and 20 polls
   localparam logic [15:0] QUICK_UNIT    = 16'd1;
   localparam logic [15:0] QUICK_TIMEOUT = 16'd20;

   // directed part; the first rows run at the reset configuration (216 ticks, 250 polls)
   localparam int PLAN_ROWS = 16;
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      '{'{i2cms_pkg::CMD_TICK,  8'h00, 1'b0, 1'b0}, 1'b0, 1'b1, 1'b0, AFTER_RESET},
      '{'{i2cms_pkg::CMD_TICK,  8'hFF, 1'b1, 1'b1}, 1'b0, 1'b1, 1'b0, AFTER_RESET},
      '{'{KIND_SPARE_6,         8'hFF, 1'b1, 1'b1}, 1'b0, 1'b1, 1'b0, AFTER_RESET},
      '{'{KIND_SPARE_7,         8'h00, 1'b0, 1'b0}, 1'b0, 1'b1, 1'b0, AFTER_RESET},
      // ack found after two units of 216 ticks
      '{'{i2cms_pkg::CMD_WACK,  8'h00, 1'b0, 1'b0}, 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{'{i2cms_pkg::CMD_START, 8'hA5, 1'b1, 1'b1}, 1'b0, 1'b0, 1'b1, NO_RESULT},
      // rejected, start busy
      '{'{i2cms_pkg::CMD_WRITE, 8'hFF, 1'b1, 1'b1}, 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{'{i2cms_pkg::CMD_STOP,  8'h00, 1'b0, 1'b0}, 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{'{i2cms_pkg::CMD_WRITE, 8'hFF, 1'b0, 1'b1}, 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{'{i2cms_pkg::CMD_WRITE, 8'h00, 1'b1, 1'b0}, 1'b1, 1'b0, 1'b0, NO_RESULT},
      // slave acks
      '{'{i2cms_pkg::CMD_WACK,  8'h00, 1'b0, 1'b0}, 1'b1, 1'b0, 1'b0, NO_RESULT},
      // no ack, times out
      '{'{i2cms_pkg::CMD_WACK,  8'hFF, 1'b1, 1'b1}, 1'b1, 1'b0, 1'b0, NO_RESULT},
      // 0xFF then ACK
      '{'{i2cms_pkg::CMD_READ,  8'h00, 1'b1, 1'b1}, 1'b1, 1'b0, 1'b0, NO_RESULT},
      // 0x00 then NACK
      '{'{i2cms_pkg::CMD_READ,  8'hFF, 1'b0, 1'b0}, 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{'{i2cms_pkg::CMD_STOP,  8'h5A, 1'b0, 1'b1}, 1'b0, 1'b0, 1'b0, NO_RESULT},
      // rejected, stop busy
      '{'{i2cms_pkg::CMD_READ,  8'h00, 1'b1, 1'b0}, 1'b1, 1'b0, 1'b0, NO_RESULT}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                              csr_we;
   logic [i2cms_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [i2cms_pkg::CSR_DATA_W-1:0]  csr_wdata;

   i2cms_req_if req();
   i2cms_rsp_if rsp();

   i2c_master_bit_sequencer_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [15:0]   cfg_unit    = i2cms_pkg::UNIT_TICKS_RESET;
   logic [7:0]    cfg_timeout = i2cms_pkg::ACK_TIMEOUT_RESET;
   seq_phase_type seq_ph      = SP_IDLE;
   logic [2:0]    act_cmd     = i2cms_pkg::CMD_TICK;
   logic [3:0]    bit_cnt     = '0;
   logic [7:0]    shreg       = '0;
   logic [15:0]   dly         = '0;
   int            units_rem   = 0;
   logic [7:0]    polls       = '0;
   logic          scl_q       = 1'b1;
   logic          sda_q       = 1'b1;
   logic          sda_dir_in  = 1'b0;
   logic          ack_sel     = 1'b0;
   logic          fail_f      = 1'b0;
   logic          done_f      = 1'b0;
   logic [7:0]    rd_last     = '0;

   tick_result_type pin_expect_q [$];
   bit              steady      = 1'b0;   // no idling on either side
   bit              stuck_high  = 1'b0;   // current ack wait sees no ack
   int              err_count   = 0;
   int              cycles      = 0;
   int              n_items     = 0;
   int              n_checked   = 0;
   int              n_cmds      = 0;
   int              n_rejects   = 0;
   int              n_ackfail   = 0;
   int              n_reads     = 0;
   tick_result_type seen;
   tick_result_type want_r;

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d beats still expected", cycles,
                  pin_expect_q.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic flag_mismatch(input string what);
      err_count++;
      if (err_count <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, what);
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         flag_mismatch($sformatf("beat %0d %s: got %0h, expected %0h", n_checked, name,
                                 got, want));
   endtask

   // ---------------------------------------------------------------- predictor
   function automatic logic [15:0] unit_len();
      return (cfg_unit == '0) ? 16'd1 : cfg_unit;
   endfunction

   function automatic void wait_units(input int n, input seq_phase_type nxt);
      units_rem = n;
      dly       = unit_len();
      seq_ph    = nxt;
   endfunction

   function automatic void close_seq();
      seq_ph = SP_IDLE;
      done_f = 1'b1;
   endfunction

   // runs phase actions until a wait, a poll or the end of the sequence
   function automatic void advance(input logic sda_in);
      bit go_on;
      for (int g = 0; g < 64; g++) begin
         go_on = 1'b0;
         case (seq_ph)
            SP_START_A: begin
               sda_dir_in = 1'b0; sda_q = 1'b1; scl_q = 1'b1;
               wait_units(4, SP_START_B);
            end
            SP_START_B: begin sda_q = 1'b0; wait_units(4, SP_START_C); end
            SP_START_C: begin scl_q = 1'b0; close_seq(); end
            SP_STOP_A: begin
               sda_dir_in = 1'b0; scl_q = 1'b0; sda_q = 1'b0;
               wait_units(4, SP_STOP_B);
            end
            SP_STOP_B: begin scl_q = 1'b1; sda_q = 1'b1; close_seq(); end
            SP_WR_INIT: begin
               sda_dir_in = 1'b0; scl_q = 1'b0; bit_cnt = '0;
               seq_ph = SP_WR_BIT; go_on = 1'b1;
            end
            SP_WR_BIT: begin
               sda_q = shreg[7];
               shreg = {shreg[6:0], 1'b0};
               wait_units(2, SP_WR_HIGH);
            end
            SP_WR_HIGH: begin scl_q = 1'b1; wait_units(2, SP_WR_LOW); end
            SP_WR_LOW: begin
               scl_q = 1'b0; bit_cnt = bit_cnt + 4'd1;
               wait_units(2, SP_WR_NEXT);
            end
            SP_WR_NEXT: begin
               if (bit_cnt >= i2cms_pkg::BITS_PER_BYTE) close_seq();
               else begin seq_ph = SP_WR_BIT; go_on = 1'b1; end
            end
            SP_ACK_REL: begin
               sda_dir_in = 1'b1; sda_q = 1'b1; polls = '0;
               wait_units(1, SP_ACK_HIGH);
            end
            SP_ACK_HIGH: begin scl_q = 1'b1; wait_units(1, SP_ACK_POLL); end
            SP_ACK_POLL: begin
               // one poll per tick; timeout falls through into a stop
               if (!sda_in) begin
                  scl_q = 1'b0; close_seq();
               end else if (polls >= cfg_timeout) begin
                  fail_f = 1'b1; seq_ph = SP_STOP_A; go_on = 1'b1;
               end else begin
                  polls = polls + 8'd1;
               end
            end
            SP_RD_INIT: begin
               sda_dir_in = 1'b1; bit_cnt = '0; shreg = '0;
               seq_ph = SP_RD_LOW; go_on = 1'b1;
            end
            SP_RD_LOW: begin scl_q = 1'b0; wait_units(2, SP_RD_HIGH); end
            SP_RD_HIGH: begin
               scl_q   = 1'b1;
               shreg   = {shreg[6:0], sda_in};
               bit_cnt = bit_cnt + 4'd1;
               wait_units(1, SP_RD_NEXT);
            end
            SP_RD_NEXT: begin
               seq_ph = (bit_cnt >= i2cms_pkg::BITS_PER_BYTE) ? SP_RD_ACK : SP_RD_LOW;
               go_on  = 1'b1;
            end
            SP_RD_ACK: begin
               scl_q = 1'b0; sda_dir_in = 1'b0; sda_q = ack_sel ? 1'b0 : 1'b1;
               wait_units(2, SP_RD_ACKH);
            end
            SP_RD_ACKH: begin scl_q = 1'b1; wait_units(2, SP_RD_ACKL); end
            SP_RD_ACKL: begin scl_q = 1'b0; rd_last = shreg; close_seq(); end
            default: seq_ph = SP_IDLE;
         endcase
         if (!go_on) return;
      end
   endfunction

   // one tick through the predictor
   task automatic predict_tick(input tick_item_type it, output tick_result_type r);
      bit is_cmd;
      bit rej;
      is_cmd = (it.kind >= i2cms_pkg::CMD_START) && (it.kind <= i2cms_pkg::CMD_READ);
      rej    = 1'b0;
      done_f = 1'b0;
      if (seq_ph == SP_IDLE) begin
         fail_f = 1'b0;
         if (is_cmd) begin
            act_cmd   = it.kind;
            units_rem = 0;
            n_cmds++;
            case (it.kind)
               i2cms_pkg::CMD_START: seq_ph = SP_START_A;
               i2cms_pkg::CMD_STOP:  seq_ph = SP_STOP_A;
               i2cms_pkg::CMD_WRITE: begin shreg = it.tx; seq_ph = SP_WR_INIT; end
               i2cms_pkg::CMD_WACK:  seq_ph = SP_ACK_REL;
               default:              begin ack_sel = it.ack; seq_ph = SP_RD_INIT; end
            endcase
            advance(it.sda);
         end
      end else begin
         rej = is_cmd;
         if (units_rem > 0) begin
            if (dly > 0) dly = dly - 16'd1;
            if (dly == 0) begin
               units_rem--;
               if (units_rem == 0) advance(it.sda);
               else dly = unit_len();
            end
         end else begin
            advance(it.sda);
         end
      end
      r.scl      = scl_q;
      r.sda      = sda_dir_in ? 1'b1 : sda_q;
      r.sda_in   = sda_dir_in;
      r.busy     = (seq_ph != SP_IDLE);
      r.done     = done_f;
      r.rdata    = rd_last;
      r.failed   = done_f && (act_cmd == i2cms_pkg::CMD_WACK) && fail_f;
      r.rejected = rej;
      if (rej) n_rejects++;
      if (r.failed) n_ackfail++;
      if (done_f && act_cmd == i2cms_pkg::CMD_READ) n_reads++;
   endtask

   // ---------------------------------------------------------------- request side
   task automatic send_beat(input tick_item_type it, input bit typed,
                            input tick_result_type want);
      int gap;
      tick_result_type p;
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid          <= 1'b1;
      req.kind           <= it.kind;
      req.tx_byte        <= it.tx;
      req.ack_after_read <= it.ack;
      req.sda_sample     <= it.sda;
      do @(posedge clock); while (req.ready !== 1'b1);
      predict_tick(it, p);
      pin_expect_q.push_back(typed ? want : p);
      n_items++;
   endtask

   task automatic tick_until_idle(input int sda_mode);
      tick_item_type it;
      while (seq_ph != SP_IDLE) begin
         it.kind = i2cms_pkg::CMD_TICK;
         it.tx   = 8'($urandom_range(0, 255));
         it.ack  = 1'($urandom_range(0, 1));
         it.sda  = (sda_mode == SDA_RANDOM) ? 1'($urandom_range(0, 1)) : sda_mode[0];
         send_beat(it, 1'b0, NO_RESULT);
      end
   endtask

   // random beat: a command when idle, mostly plain ticks while a sequence runs
   task automatic pick_item(output tick_item_type it);
      int r;
      r       = $urandom_range(0, 99);
      it.tx   = 8'($urandom_range(0, 255));
      it.ack  = 1'($urandom_range(0, 1));
      it.sda  = 1'($urandom_range(0, 1));
      if (seq_ph == SP_IDLE) begin
         if (r < 6) it.kind = i2cms_pkg::CMD_TICK;
         else if (r < 8) it.kind = KIND_SPARE_6;
         else if (r < 10) it.kind = KIND_SPARE_7;
         else it.kind = 3'($urandom_range(i2cms_pkg::CMD_START, i2cms_pkg::CMD_READ));
         stuck_high = (it.kind == i2cms_pkg::CMD_WACK) && ($urandom_range(0, 2) == 0);
      end else begin
         if (r < 6) it.kind = 3'($urandom_range(i2cms_pkg::CMD_START, i2cms_pkg::CMD_READ));
         else if (r < 8) it.kind = r[0] ? KIND_SPARE_7 : KIND_SPARE_6;
         else it.kind = i2cms_pkg::CMD_TICK;
         if (stuck_high) it.sda = 1'b1;
      end
   endtask

   // hold off until every expected beat is back and the pipe is empty
   task automatic settle();
      req.valid <= 1'b0;
      while (pin_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] unit_w, input logic [15:0] tmo_w);
      csr_we    <= 1'b1;
      csr_index <= i2cms_pkg::CSR_UNIT_TICKS;
      csr_wdata <= unit_w;
      @(posedge clock);
      csr_index <= i2cms_pkg::CSR_ACK_TIMEOUT;
      csr_wdata <= tmo_w;
      @(posedge clock);
      csr_we      <= 1'b0;
      cfg_unit    = unit_w;
      cfg_timeout = tmo_w[7:0];
   endtask

   // ---------------------------------------------------------------- response side
   initial begin
      int gap;
      rsp.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         gap = steady ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (rsp.valid !== 1'b1);
      end
   end

   // compare each accepted beat with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         n_checked++;
         seen = '{rsp.scl_level, rsp.sda_level, rsp.sda_is_input, rsp.busy_res,
                  rsp.done_res, rsp.read_data, rsp.ack_failed, rsp.rejected};
         if (pin_expect_q.size() == 0) begin
            flag_mismatch($sformatf("beat %0d arrived with nothing expected", n_checked));
         end else begin
            want_r = pin_expect_q.pop_front();
            check_field("scl_level",    8'(seen.scl),      8'(want_r.scl));
            check_field("sda_level",    8'(seen.sda),      8'(want_r.sda));
            check_field("sda_is_input", 8'(seen.sda_in),   8'(want_r.sda_in));
            check_field("busy_res",     8'(seen.busy),     8'(want_r.busy));
            check_field("done_res",     8'(seen.done),     8'(want_r.done));
            check_field("read_data",    seen.rdata,        want_r.rdata);
            check_field("ack_failed",   8'(seen.failed),   8'(want_r.failed));
            check_field("rejected",     8'(seen.rejected), 8'(want_r.rejected));
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   initial begin
      tick_item_type it;
      logic [15:0] unit_w;
      logic [7:0]  tmo;
      req.valid          <= 1'b0;
      req.kind           <= i2cms_pkg::CMD_TICK;
      req.tx_byte        <= '0;
      req.ack_after_read <= 1'b0;
      req.sda_sample     <= 1'b0;
      csr_we             <= 1'b0;
      csr_index          <= i2cms_pkg::CSR_UNIT_TICKS;
      csr_wdata          <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed rows, no idling
      steady = 1'b1;
      foreach (PLAN[i]) begin
         if (PLAN[i].quick) begin
            settle();
            set_config(QUICK_UNIT, QUICK_TIMEOUT);
         end
         send_beat(PLAN[i].stim, PLAN[i].typed, PLAN[i].want);
         if (PLAN[i].hold) tick_until_idle(int'(PLAN[i].stim.sda));
      end

      // zero unit count runs as one tick; 255 polls saturate and fail on the 256th
      settle();
      set_config(16'h0000, 16'hA5FF);
      it = '{i2cms_pkg::CMD_WACK, 8'hFF, 1'b1, 1'b1};
      send_beat(it, 1'b0, NO_RESULT);
      tick_until_idle(SDA_HIGH);
      steady = 1'b0;

      // random phases, each at its own configuration
      for (int ph_i = 0; ph_i < RAND_PHASES; ph_i++) begin
         settle();
         case (ph_i)
            0:       begin unit_w = 16'd1; tmo = 8'd1; end
            1:       begin unit_w = 16'd0; tmo = 8'($urandom_range(1, 30)); end
            default: begin
               unit_w = 16'($urandom_range(1, 3));
               tmo    = 8'($urandom_range(1, 30));
            end
         endcase
         set_config(unit_w, {8'($urandom_range(0, 255)), tmo});
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (k % 50 == 0) steady = ($urandom_range(0, 4) == 0);
            pick_item(it);
            send_beat(it, 1'b0, NO_RESULT);
         end
         tick_until_idle(stuck_high ? SDA_HIGH : SDA_RANDOM);
         steady = 1'b0;
      end

      settle();
      if (pin_expect_q.size() != 0)
         flag_mismatch($sformatf("%0d expected beats never arrived", pin_expect_q.size()));
      $display("Ran %0d request beats and checked %0d response beats in %0d cycles,",
               n_items, n_checked, cycles);
      $display("  %0d commands, %0d rejected while busy, %0d ack timeouts, %0d reads.",
               n_cmds, n_rejects, n_ackfail, n_reads);
      if (err_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", err_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
